// ===== rtl/core/bpra_pkg.sv =====
// Shared types and constants of the bitmap page run allocator.
`default_nettype none
package bpra_pkg;
   localparam int CfgIdxW = 2;
   localparam int PagesW  = 13;
   localparam int AddrW   = 32;

   typedef enum logic [CfgIdxW-1:0] {
      REG_KERNEL_BASE  = 2'd0,
      REG_USER_BASE    = 2'd1,
      REG_KERNEL_PAGES = 2'd2,
      REG_USER_PAGES   = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic scan_step;
      logic mark_step;
      logic resp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic scan_done;
      logic found;
      logic mark_done;
   } status_type;
endpackage
`default_nettype wire

// ===== rtl/core/bpra_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module bpra_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== rtl/core/bpra_ctrl.sv =====
// Controller state machine of the bitmap page run allocator.
`default_nettype none
module bpra_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire bpra_pkg::status_type  status,
   output bpra_pkg::cmd_type          cmd
);
   import bpra_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (status.clear_done) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid) state_in = ST_SCAN;
         ST_SCAN: begin
            if (status.found) begin
               state_in = ST_MARK;
            end else if (status.scan_done) begin
               state_in = ST_RESP;
            end
         end
         ST_MARK:  if (status.mark_done) state_in = ST_RESP;
         ST_RESP:  if (rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.resp_load = status.scan_done && !status.found;
         end
         ST_MARK: begin
            cmd.mark_step = 1'b1;
            cmd.resp_load = status.mark_done;
         end
         ST_RESP:  rsp_valid = 1'b1;
         default:  cmd = '0;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/core/bpra_dp.sv =====
// Datapath of the allocator: bitmap memories, scan and mark counters, result.
`default_nettype none
module bpra_dp #(
   parameter int PoolPages = 4096,
   parameter int PageBytes = 4096
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire bpra_pkg::cmd_type           cmd,
   output bpra_pkg::status_type             status,
   input  wire logic                        csr_valid,
   input  wire logic [1:0]                  csr_index,
   input  wire logic [31:0]                 csr_data,
   input  wire logic                        req_pool_select,
   input  wire logic [12:0]                 req_page_count,
   output logic      [31:0]                 rsp_start_address,
   output logic                             rsp_failed
);
   import bpra_pkg::*;

   localparam int IdxW  = $clog2(PoolPages);
   localparam int CntW  = IdxW + 1;
   localparam int ShW   = $clog2(PageBytes);
   localparam int LimW  = (CntW > PagesW) ? CntW : PagesW;

   logic [AddrW-1:0]  kbase_ff, ubase_ff;
   logic [PagesW-1:0] kpages_ff, upages_ff;

   logic              pool_ff;
   logic [PagesW-1:0] len_ff;
   logic [CntW-1:0]   limit_ff;
   logic [AddrW-1:0]  base_ff;
   logic [CntW-1:0]   addr_ff;     // address being issued to the RAM
   logic [CntW-1:0]   chk_ff;      // index whose read data arrives now
   logic              chk_vld_ff;
   logic [PagesW-1:0] run_ff;
   logic [CntW-1:0]   start_ff;
   logic [PagesW-1:0] mark_cnt_ff;
   logic              done_ff;     // set on a hit
   logic [AddrW-1:0]  addr_out_ff;
   logic              fail_ff;

   logic              rd_k, rd_u, rd_bit;
   logic              wr_k, wr_u;
   logic [IdxW-1:0]   ram_addr;
   logic [PagesW-1:0] run_in;
   logic              hit;
   logic [LimW-1:0]   lim_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         kbase_ff  <= '0;
         ubase_ff  <= '0;
         kpages_ff <= '0;
         upages_ff <= '0;
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_KERNEL_BASE:  kbase_ff  <= csr_data;
            REG_USER_BASE:    ubase_ff  <= csr_data;
            REG_KERNEL_PAGES: kpages_ff <= csr_data[PagesW-1:0];
            REG_USER_PAGES:   upages_ff <= csr_data[PagesW-1:0];
            default:          kbase_ff  <= kbase_ff;
         endcase
      end
   end

   assign lim_sel = req_pool_select ? LimW'(upages_ff) : LimW'(kpages_ff);

   always_comb begin
      if (cmd.mark_step) begin
         ram_addr = IdxW'(start_ff + CntW'(mark_cnt_ff));
      end else begin
         ram_addr = addr_ff[IdxW-1:0];
      end
   end

   assign wr_k   = cmd.clear_step || (cmd.mark_step && !pool_ff);
   assign wr_u   = cmd.clear_step || (cmd.mark_step && pool_ff);
   assign rd_bit = pool_ff ? rd_u : rd_k;
   assign run_in = rd_bit ? '0 : run_ff + 1'b1;
   assign hit    = cmd.scan_step && chk_vld_ff && !done_ff && !rd_bit
                   && (chk_ff != limit_ff) && (run_in == len_ff);

   bpra_ram #(.Width(1), .Depth(PoolPages)) u_kmap (
      .clock, .wr_en(wr_k), .addr(ram_addr), .wr_data(cmd.mark_step), .rd_data(rd_k)
   );
   bpra_ram #(.Width(1), .Depth(PoolPages)) u_umap (
      .clock, .wr_en(wr_u), .addr(ram_addr), .wr_data(cmd.mark_step), .rd_data(rd_u)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff    <= '0;
         chk_vld_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else if (cmd.clear_step) begin
         addr_ff <= addr_ff + 1'b1;
      end else if (cmd.load) begin
         pool_ff     <= req_pool_select;
         len_ff      <= req_page_count;
         limit_ff    <= (lim_sel > LimW'(PoolPages)) ? CntW'(PoolPages)
                                                     : CntW'(lim_sel);
         base_ff     <= req_pool_select ? ubase_ff : kbase_ff;
         addr_ff     <= '0;
         chk_ff      <= '0;
         chk_vld_ff  <= 1'b0;
         run_ff      <= '0;
         mark_cnt_ff <= '0;
         done_ff     <= 1'b0;
      end else if (cmd.scan_step) begin
         chk_vld_ff <= 1'b1;
         if (chk_vld_ff) begin
            chk_ff <= chk_ff + 1'b1;
            run_ff <= run_in;
         end
         addr_ff <= addr_ff + 1'b1;
         if (hit) begin
            start_ff <= CntW'(CntW'(chk_ff) + 1'b1 - CntW'(len_ff));
            done_ff  <= 1'b1;
         end
      end else if (cmd.mark_step) begin
         mark_cnt_ff <= mark_cnt_ff + 1'b1;
      end
   end

   // Scan gives up when the count is zero, exceeds the range, or the range is walked.
   always_comb begin
      status.clear_done = (addr_ff == CntW'(PoolPages - 1));
      status.found      = hit;
      status.scan_done  = (len_ff == '0) || (LimW'(len_ff) > LimW'(limit_ff)) ||
                          (chk_vld_ff && (chk_ff == limit_ff)) || hit;
      status.mark_done  = (mark_cnt_ff + 1'b1 == len_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.resp_load) begin
         fail_ff     <= !cmd.mark_step;
         addr_out_ff <= cmd.mark_step
                        ? base_ff + (AddrW'(start_ff) << ShW) : '0;
      end
   end

   assign rsp_start_address = addr_out_ff;
   assign rsp_failed        = fail_ff;
endmodule
`default_nettype wire

// ===== rtl/core/bitmap_page_run_allocator.sv =====
// Top level of the bitmap first-fit page run allocator.
// Usage: a transaction on the req_ channel names a pool (0 kernel, 1 user)
// and a page count. The block walks that pool's used-page bitmap one page a
// cycle from index zero, finds the lowest free run of the requested length,
// marks it used one page a cycle, and answers with one transaction on the
// rsp_ channel: the base plus run index times the page size, or failed set
// and address zero. A miss leaves the bitmap unchanged.
// One request is handled at a time, and each pool's bitmap has a single RAM
// port. After reset the block sweeps both bitmaps clear while req_ready
// stays low; csr_ writes are accepted at all times.
// While the receiver stalls, the result is held in its register and no new
// request is taken. Configure the csr_ registers only while idle.
`default_nettype none
module bitmap_page_run_allocator #(
   parameter int POOL_PAGES = 4096,
   parameter int PAGE_BYTES = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_pool_select,
   input  wire logic [12:0] req_page_count,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_start_address,
   output logic             rsp_failed
);
   import bpra_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   bpra_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd
   );

   bpra_dp #(.PoolPages(POOL_PAGES), .PageBytes(PAGE_BYTES)) u_dp (
      .clock, .reset, .cmd, .status, .csr_valid, .csr_index, .csr_data,
      .req_pool_select, .req_page_count, .rsp_start_address, .rsp_failed
   );
endmodule
`default_nettype wire

// ===== tb/sv/bitmap_page_run_allocator_tb.sv =====
// Self-checking testbench for the bitmap first-fit page run allocator.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_page_run_allocator_tb;
   import bpra_pkg::*;

   // Full pool size and page size, as the block is built here.
   localparam int MapPages  = 4096;
   localparam int PageBytes = 4096;
   // Cycles with no transaction on any channel before the run is called hung.
   // The slowest correct request walks and marks a whole pool, and the
   // clearing sweep after reset covers a whole pool as well.
   localparam int StallLimit = 40000;
   localparam int LongHold   = 500;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;
   logic        req_valid;
   logic        req_ready;
   logic        req_pool_select;
   logic [12:0] req_page_count;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_start_address;
   logic        rsp_failed;

   bitmap_page_run_allocator DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pool_select  (req_pool_select),
      .req_page_count   (req_page_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_start_address(rsp_start_address),
      .rsp_failed       (rsp_failed)
   );

   // One expected allocation answer.
   typedef struct {
      bit [31:0] addr;
      bit        fail;
   } alloc_answer_type;

   // One row of the directed table. When typed is set, the answer is written
   // into the row and replaces the predicted one.
   typedef struct {
      bit        pool;
      bit [12:0] count;
      bit        typed;
      bit [31:0] addr;
      bit        fail;
   } alloc_row_type;

   // Our own copy of the block's configuration and bitmaps.
   bit [31:0] kernel_base_q, user_base_q;
   bit [12:0] kernel_pages_q, user_pages_q;
   bit        kernel_used[MapPages];
   bit        user_used[MapPages];

   alloc_answer_type pending_answers[$];
   int               error_count;
   int               quiet_cycles;

   // Control shared between the stimulus process, the prediction and the response sink.
   bit        idle_enable;
   bit        hold_request;
   bit        hold_taken;
   bit        row_typed;
   bit [31:0] row_addr;
   bit        row_fail;

   // The first rows run against the reset configuration, where both pools
   // manage zero pages and every request must fail.
   localparam int ResetRows = 3;
   alloc_row_type directed_rows[14] = '{
      '{1'b0, 13'd1,    1'b1, 32'h0, 1'b1},
      '{1'b1, 13'd1,    1'b1, 32'h0, 1'b1},
      '{1'b0, 13'd0,    1'b1, 32'h0, 1'b1},
      // From here on: kernel base at the top page, user base unaligned,
      // kernel size written above the pool size, user size at the pool size.
      '{1'b0, 13'd0,    1'b1, 32'h0, 1'b1},
      '{1'b0, 13'd8191, 1'b1, 32'h0, 1'b1},
      '{1'b0, 13'd4097, 1'b1, 32'h0, 1'b1},
      '{1'b1, 13'd1,    1'b1, 32'h1234_5679, 1'b0},
      '{1'b1, 13'd4096, 1'b1, 32'h0, 1'b1},
      '{1'b0, 13'd1,    1'b1, 32'hFFFF_F000, 1'b0},
      // The second kernel page lies just past the top of the address space.
      '{1'b0, 13'd2,    1'b1, 32'h0, 1'b0},
      '{1'b0, 13'd4096, 1'b1, 32'h0, 1'b1},
      '{1'b0, 13'd1,    1'b0, 32'h0, 1'b0},
      '{1'b1, 13'd3,    1'b0, 32'h0, 1'b0},
      '{1'b1, 13'd2730, 1'b0, 32'h0, 1'b0}
   };

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input bit [31:0] got,
                                  input bit [31:0] want);
      $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // First-fit search in the selected pool. On a hit the run is marked used.
   function automatic alloc_answer_type allocate_run(input bit pool, input bit [12:0] count);
      alloc_answer_type answer;
      int limit;
      int run;
      bit used;
      answer.addr = '0;
      answer.fail = 1'b1;
      limit = pool ? user_pages_q : kernel_pages_q;
      if (limit > MapPages) limit = MapPages;
      run = 0;
      if (count != 0 && count <= limit) begin
         for (int i = 0; i < limit; i++) begin
            used = pool ? user_used[i] : kernel_used[i];
            run = used ? 0 : run + 1;
            if (run == count) begin
               for (int k = i + 1 - count; k <= i; k++) begin
                  if (pool) user_used[k] = 1'b1;
                  else kernel_used[k] = 1'b1;
               end
               // The sum wraps at 32 bits, and the base is not masked.
               answer.addr = (pool ? user_base_q : kernel_base_q)
                             + 32'(i + 1 - count) * 32'(PageBytes);
               answer.fail = 1'b0;
               break;
            end
         end
      end
      return answer;
   endfunction

   // Writes all four registers back to back; valid stays high between them.
   task automatic write_config(input bit [31:0] kbase, input bit [31:0] ubase,
                               input bit [12:0] kpages, input bit [12:0] upages);
      reg_index_type ri;
      ri = ri.first();
      for (int n = 0; n < 4; n++) begin
         csr_valid <= 1'b1;
         csr_index <= ri;
         case (ri)
            REG_KERNEL_BASE:  csr_data <= kbase;
            REG_USER_BASE:    csr_data <= ubase;
            REG_KERNEL_PAGES: csr_data <= {19'd0, kpages};
            default:          csr_data <= {19'd0, upages};
         endcase
         do @(posedge clock); while (!csr_ready);
         case (ri)
            REG_KERNEL_BASE:  kernel_base_q = kbase;
            REG_USER_BASE:    user_base_q = ubase;
            REG_KERNEL_PAGES: kernel_pages_q = kpages;
            default:          user_pages_q = upages;
         endcase
         ri = ri.next();
      end
      csr_valid <= 1'b0;
   endtask

   // Offers one request and holds it until the block takes it. A random gap
   // may come first; valid only drops inside that gap, never in the same
   // time step that raises it again.
   task automatic send_request(input bit pool, input bit [12:0] count);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pool_select <= pool;
      req_page_count  <= count;
      do @(posedge clock); while (!req_ready);
   endtask

   // The extra edge lets the prediction of the last accepted request land first.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic bit [31:0] pick_base();
      case ($urandom_range(0, 5))
         0:       return 32'h0;
         1:       return 32'hFFFF_F000;
         2:       return 32'hFFFF_FFFF;
         3:       return {20'($urandom_range(0, 32'hF_FFFF)), 12'h000};
         default: return $urandom();
      endcase
   endfunction

   function automatic bit [12:0] pick_count();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 85) return 13'($urandom_range(1, 6));
      if (roll < 95) return 13'($urandom_range(0, 40));
      return 13'($urandom());
   endfunction

   // Prediction happens at the accepting edge, in order of acceptance.
   always @(posedge clock) begin
      alloc_answer_type answer;
      if (!reset && req_valid && req_ready) begin
         answer = allocate_run(req_pool_select, req_page_count);
         if (row_typed) begin
            answer.addr = row_addr;
            answer.fail = row_fail;
         end
         pending_answers.push_back(answer);
      end
   end

   // Response sink: checks each result transaction and paces rsp_ready.
   always @(posedge clock) begin
      alloc_answer_type want;
      int gap_left;
      int hold_left;
      bit next_ready;
      if (reset) begin
         gap_left   = 0;
         hold_left  = 0;
         hold_taken = 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               report_mismatch("unexpected result", rsp_start_address, 32'h0);
            end else begin
               want = pending_answers.pop_front();
               if (rsp_start_address !== want.addr)
                  report_mismatch("start_address", rsp_start_address, want.addr);
               if (rsp_failed !== want.fail)
                  report_mismatch("failed", {31'd0, rsp_failed}, {31'd0, want.fail});
            end
         end
         // A long hold-off lets the block fill up and stall its input. It is
         // taken once for each request of one.
         if (!hold_request) begin
            hold_taken = 1'b0;
         end else if (!hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LongHold;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
            if (idle_enable && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 15);
         end
         rsp_ready <= next_ready;
      end
   end

   // Watchdog on cycles with no transaction anywhere.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("FAIL bitmap_page_run_allocator");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      bit [12:0] kp, up;
      int cap;
      reset           <= 1'b1;
      csr_valid       <= 1'b0;
      csr_index       <= REG_KERNEL_BASE;
      csr_data        <= '0;
      req_valid       <= 1'b0;
      req_pool_select <= 1'b0;
      req_page_count  <= '0;
      row_typed       <= 1'b0;
      row_addr        <= '0;
      row_fail        <= 1'b0;
      error_count     = 0;
      idle_enable     = 1'b1;
      hold_request    = 1'b0;
      kernel_base_q   = '0;
      user_base_q     = '0;
      kernel_pages_q  = '0;
      user_pages_q    = '0;
      for (int i = 0; i < MapPages; i++) begin
         kernel_used[i] = 1'b0;
         user_used[i]   = 1'b0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: reset configuration first, then the extreme settings.
      // The row fields follow the request they belong to onto the port.
      foreach (directed_rows[r]) begin
         if (r == ResetRows) begin
            wait_drained();
            write_config(32'hFFFF_F000, 32'h1234_5679, 13'd8191, 13'd4096);
         end
         row_typed <= directed_rows[r].typed;
         row_addr  <= directed_rows[r].addr;
         row_fail  <= directed_rows[r].fail;
         send_request(directed_rows[r].pool, directed_rows[r].count);
      end
      row_typed <= 1'b0;
      wait_drained();

      // Random part: pool sizes grow from phase to phase and sometimes
      // shrink, so used pages beyond a lowered size come back into view.
      for (int phase = 0; phase < 12; phase++) begin
         cap = 24 + 40 * phase;
         kp  = 13'($urandom_range(8, cap));
         up  = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 7))
                                           : 13'($urandom_range(8, cap));
         write_config(pick_base(), pick_base(), kp, up);
         if (phase == 11) idle_enable = 1'b0;
         for (int n = 0; n < 140; n++) begin
            if (phase == 1 && n == 10) hold_request = 1'b1;
            if (phase == 1 && n == 11) hold_request = 1'b0;
            send_request($urandom_range(0, 1), pick_count());
         end
         wait_drained();
      end

      // Full pool sizes at the end, with whole-pool walks kept to a few.
      write_config(pick_base(), pick_base(), 13'd4096, 13'd8191);
      for (int n = 0; n < 16; n++) begin
         case (n % 4)
            0:       send_request(n[2], 13'd4096);
            1:       send_request(n[2], 13'($urandom_range(1, 3000)));
            2:       send_request(n[2], 13'($urandom()));
            default: send_request(n[2], 13'd1);
         endcase
      end
      wait_drained();
      repeat (50) @(posedge clock);

      if (error_count == 0) begin
         $display("PASS bitmap_page_run_allocator");
      end else begin
         $display("FAIL bitmap_page_run_allocator");
      end
      $finish;
   end
endmodule
`default_nettype wire
